/* sv/assert_macros.svh */
// assertion macros used by the rtl top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked at every rising clock edge once reset is released
`define ASSERT_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_CHK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)

`endif

`endif

/* sv/gfbs_pkg.sv */
// types and constants of the grouped free block stack
`timescale 1ns / 1ps

package gfbs_pkg;

  // block number width
  localparam int BNO_W = 10;

  typedef logic [BNO_W-1:0] bno_t;

  // request opcodes
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  // response status codes
  typedef enum logic {
    ST_OK    = 1'b0,
    ST_EMPTY = 1'b1
  } status_e;

endpackage

/* sv/gfbs_req_if.sv */
// request channel: opcode and block number
`timescale 1ns / 1ps

interface gfbs_req_if import gfbs_pkg::*; ();
  logic valid;
  logic ready;
  logic opcode;
  bno_t block_number;

  modport source (output valid, output opcode, output block_number, input ready);
  modport sink (input valid, input opcode, input block_number, output ready);
endinterface

/* sv/gfbs_rsp_if.sv */
// response channel: granted block and status
`timescale 1ns / 1ps

interface gfbs_rsp_if import gfbs_pkg::*; ();
  logic valid;
  logic ready;
  bno_t granted_block;
  logic status;

  modport source (output valid, output granted_block, output status, input ready);
  modport sink (input valid, input granted_block, input status, output ready);
endinterface

/* sv/grouped_free_block_stack_top.sv */
// grouped free block stack: top stack memory, spill memory and sequencer
//
// channel  dir  handshake      payload
// req_i    in   valid/ready    opcode, block_number
// rsp_o    out  valid/ready    granted_block, status
//
// one item at a time; ready is high while the sequencer waits for an item.
// free on a non-full stack writes the top stack memory directly; allocate
// from the stack adds a state for the top stack memory read register.
// spill on a free to a full stack and refill on an allocate of the base
// first reduce the block number to its group index by reciprocal multiply
// (quotient, then remainder), then form the group address, then move one
// memory word per cycle.
// the result register lets the next item in while a result waits to be taken.
// rst_ni sets the pointer to one and clears the base asynchronously; memories are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grouped_free_block_stack_top import gfbs_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  parameter int NUM_BLOCKS  = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  gfbs_req_if.sink           req_i,
  gfbs_rsp_if.source         rsp_o
);

  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int GRP_W       = $clog2(NUM_BLOCKS);
  localparam int SPILL_DEPTH = NUM_BLOCKS * STACK_DEPTH;
  localparam int ADDR_W      = $clog2(SPILL_DEPTH);
  // reciprocal of NUM_BLOCKS, exact for every block number
  localparam int RCP_SH      = BNO_W + $clog2(NUM_BLOCKS);
  localparam int RCP_W       = BNO_W + 2;
  localparam int PROD_W      = BNO_W + RCP_W;
  localparam int RCP_M       = int'(((longint'(1) << RCP_SH) + longint'(NUM_BLOCKS) - 1)
                                    / longint'(NUM_BLOCKS));

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_POP   = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_GADDR = 7'b0001000,
    S_SPILL = 7'b0010000,
    S_FILL  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  logic [SP_W-1:0]      sp_q, sp_d;
  bno_t                 base_q, base_d;
  logic                 op_q, op_d;
  bno_t                 bno_q, bno_d;
  bno_t                 mod_val_q, mod_val_d;
  bno_t                 quo_q, quo_d;
  logic                 mod_step_q, mod_step_d;
  logic [GRP_W-1:0]     rem_q, rem_d;
  logic [SP_W-1:0]      cnt_q, cnt_d;
  logic [ADDR_W-1:0]    spill_addr_q, spill_addr_d;
  bno_t                 res_granted_q, res_granted_d;
  logic                 res_status_q, res_status_d;
  logic                 out_valid_q, out_valid_d;
  bno_t                 out_granted_q, out_granted_d;
  logic                 out_status_q, out_status_d;

  // memories and their ports
  bno_t                 top_mem [STACK_DEPTH];
  bno_t                 spill_mem [SPILL_DEPTH];
  bno_t                 top_rd_q;
  bno_t                 spill_rd_q;
  logic                 top_we, top_re;
  logic [IDX_W-1:0]     top_waddr, top_raddr;
  bno_t                 top_wdata;
  logic                 spill_we, spill_re;
  bno_t                 spill_wdata;

  logic                 req_acc;
  logic [PROD_W-1:0]    rcp_prod;
  bno_t                 quo_nx;
  bno_t                 rem_full;
  logic                 push_acc;
  logic                 empty_acc;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  // group index: quotient by reciprocal multiply, then remainder
  assign rcp_prod = PROD_W'(mod_val_q) * PROD_W'(RCP_M);
  assign quo_nx   = bno_t'(rcp_prod >> RCP_SH);
  assign rem_full = mod_val_q - bno_t'(quo_q * bno_t'(NUM_BLOCKS));

  // sequencer
  always_comb begin
    state_d       = state_q;
    sp_d          = sp_q;
    base_d        = base_q;
    op_d          = op_q;
    bno_d         = bno_q;
    mod_val_d     = mod_val_q;
    quo_d         = quo_q;
    mod_step_d    = mod_step_q;
    rem_d         = rem_q;
    cnt_d         = cnt_q;
    spill_addr_d  = spill_addr_q;
    res_granted_d = res_granted_q;
    res_status_d  = res_status_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_granted_d = out_granted_q;
    out_status_d  = out_status_q;
    top_we        = 1'b0;
    top_waddr     = '0;
    top_wdata     = req_i.block_number;
    top_re        = 1'b0;
    top_raddr     = '0;
    spill_we      = 1'b0;
    spill_wdata   = top_rd_q;
    spill_re      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          op_d  = req_i.opcode;
          bno_d = req_i.block_number;
          if (req_i.opcode == OP_FREE) begin
            if (sp_q < SP_W'(STACK_DEPTH)) begin
              // push onto the top stack
              top_we        = 1'b1;
              top_waddr     = IDX_W'(sp_q);
              sp_d          = sp_q + SP_W'(1);
              res_granted_d = '0;
              res_status_d  = ST_OK;
              state_d       = S_RESP;
            end else begin
              // full stack goes to the freed block's group
              mod_val_d  = req_i.block_number;
              mod_step_d = 1'b0;
              state_d    = S_MOD;
            end
          end else begin
            if (sp_q != SP_W'(1)) begin
              // pop the top entry
              top_re    = 1'b1;
              top_raddr = IDX_W'(sp_q - SP_W'(1));
              sp_d      = sp_q - SP_W'(1);
              state_d   = S_POP;
            end else if (base_q == '0) begin
              res_granted_d = '0;
              res_status_d  = ST_EMPTY;
              state_d       = S_RESP;
            end else begin
              // grant the base and reload its group
              res_granted_d = base_q;
              res_status_d  = ST_OK;
              mod_val_d     = base_q;
              mod_step_d    = 1'b0;
              state_d       = S_MOD;
            end
          end
        end
      end

      S_POP: begin
        res_granted_d = top_rd_q;
        res_status_d  = ST_OK;
        state_d       = S_RESP;
      end

      S_MOD: begin
        if (!mod_step_q) begin
          quo_d      = quo_nx;
          mod_step_d = 1'b1;
        end else begin
          rem_d   = GRP_W'(rem_full);
          state_d = S_GADDR;
        end
      end

      S_GADDR: begin
        spill_addr_d = ADDR_W'(rem_q) * ADDR_W'(STACK_DEPTH);
        cnt_d        = '0;
        state_d      = (op_q == OP_FREE) ? S_SPILL : S_FILL;
      end

      S_SPILL: begin
        // read entry cnt+1 while writing entry cnt to the group
        top_re       = 1'b1;
        top_raddr    = IDX_W'(cnt_q + SP_W'(1));
        spill_we     = 1'b1;
        spill_wdata  = (cnt_q == '0) ? base_q : top_rd_q;
        spill_addr_d = spill_addr_q + ADDR_W'(1);
        cnt_d        = cnt_q + SP_W'(1);
        if (cnt_q == SP_W'(STACK_DEPTH - 1)) begin
          base_d        = bno_q;
          sp_d          = SP_W'(1);
          res_granted_d = '0;
          res_status_d  = ST_OK;
          state_d       = S_RESP;
        end
      end

      S_FILL: begin
        // read group entry cnt, write entry cnt-1 into the stack
        if (cnt_q < SP_W'(STACK_DEPTH)) begin
          spill_re     = 1'b1;
          spill_addr_d = spill_addr_q + ADDR_W'(1);
        end
        if (cnt_q == SP_W'(1)) begin
          base_d = spill_rd_q;
        end else if (cnt_q != '0) begin
          top_we    = 1'b1;
          top_waddr = IDX_W'(cnt_q - SP_W'(1));
          top_wdata = spill_rd_q;
        end
        cnt_d = cnt_q + SP_W'(1);
        if (cnt_q == SP_W'(STACK_DEPTH)) begin
          sp_d    = SP_W'(STACK_DEPTH);
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d   = 1'b1;
          out_granted_d = res_granted_q;
          out_status_d  = res_status_q;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= SP_W'(1);
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    bno_q         <= bno_d;
    mod_val_q     <= mod_val_d;
    quo_q         <= quo_d;
    mod_step_q    <= mod_step_d;
    rem_q         <= rem_d;
    cnt_q         <= cnt_d;
    spill_addr_q  <= spill_addr_d;
    res_granted_q <= res_granted_d;
    res_status_q  <= res_status_d;
    out_granted_q <= out_granted_d;
    out_status_q  <= out_status_d;
  end

  // top stack memory, entry 0 lives in base_q
  always_ff @(posedge clk_i) begin
    if (top_we) begin
      top_mem[top_waddr] <= top_wdata;
    end
    if (top_re) begin
      top_rd_q <= top_mem[top_raddr];
    end
  end

  // spill memory, one group of STACK_DEPTH words per block
  always_ff @(posedge clk_i) begin
    if (spill_we) begin
      spill_mem[spill_addr_q] <= spill_wdata;
    end
    if (spill_re) begin
      spill_rd_q <= spill_mem[spill_addr_q];
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.granted_block = out_granted_q;
  assign rsp_o.status        = out_status_q;

  // accepted items that the checks below look at
  assign push_acc  = req_acc && (req_i.opcode == OP_FREE) && (sp_q < SP_W'(STACK_DEPTH));
  assign empty_acc = req_acc && (req_i.opcode == OP_ALLOC) && (sp_q == SP_W'(1)) &&
                     (base_q == '0);

  // pointer stays within one to full
  `ASSERT_CHK(a_sp_range, (sp_q >= SP_W'(1)) && (sp_q <= SP_W'(STACK_DEPTH)))
  // a push on a non-full stack bumps the pointer by one
  `ASSERT_CHK(a_push_incr, push_acc |=> (sp_q == $past(sp_q) + SP_W'(1)))
  // an allocate on an empty list answers empty at once
  `ASSERT_CHK(a_empty_rsp, empty_acc |=> (state_q == S_RESP && res_status_q == ST_EMPTY))
  // a new result only comes from the result stage
  `ASSERT_CHK(a_out_from_resp, $rose(out_valid_q) |-> $past(state_q == S_RESP))

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the grouped free block stack
`timescale 1ns / 1ps

module tb_top;
  import gfbs_pkg::*;

  localparam int DEPTH     = 16;
  localparam int NBLK      = 1024;
  localparam int RAND_REQS = 1030;
  localparam int TAIL_CYC  = 40;
  localparam int MAX_CYC   = 400000;

  // one request as queued for the driver
  typedef struct {
    op_e  op;
    bno_t bno;
    int   gap;
    bit   drain;
  } freelist_req_t;

  // one predicted response
  typedef struct {
    bno_t    block;
    status_e status;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gfbs_req_if req_if ();
  gfbs_rsp_if rsp_if ();

  grouped_free_block_stack_top #(
    .STACK_DEPTH(DEPTH),
    .NUM_BLOCKS (NBLK)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  // shadow copy of the free list
  bno_t shadow_top[DEPTH] = '{default: '0};
  bno_t shadow_spill[NBLK][DEPTH];
  int   shadow_ptr = 1;

  freelist_req_t req_backlog[$];
  grant_t        pending_grants[$];

  int unsigned n_sent = 0;
  int unsigned n_got = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // driver and monitor private state
  int   issued = 0;
  int   hold = 0;
  logic nxt_valid;
  logic nxt_ready;
  int   rsp_stall = 0;
  bit   rsp_calm = 0;
  grant_t got_exp;

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // free list behavior for one request
  function automatic grant_t apply_request(input op_e op, input bno_t bno);
    grant_t g;
    int unsigned grp;
    g.block  = '0;
    g.status = ST_OK;
    if (op == OP_FREE) begin
      if (shadow_ptr >= DEPTH) begin
        // full stack spills into the freed block's group
        grp = bno % NBLK;
        for (int i = 0; i < DEPTH; i++) shadow_spill[grp][i] = shadow_top[i];
        shadow_top[0] = bno;
        shadow_ptr = 1;
      end else begin
        shadow_top[shadow_ptr] = bno;
        shadow_ptr++;
      end
    end else if (shadow_ptr == 1) begin
      if (shadow_top[0] == '0) begin
        g.status = ST_EMPTY;
      end else begin
        // grant the base and reload its group
        g.block = shadow_top[0];
        grp = shadow_top[0] % NBLK;
        for (int i = 0; i < DEPTH; i++) shadow_top[i] = shadow_spill[grp][i];
        shadow_ptr = DEPTH;
      end
    end else begin
      g.block = shadow_top[shadow_ptr-1];
      shadow_ptr--;
    end
    return g;
  endfunction

  function automatic bno_t pick_block();
    int r;
    r = $urandom_range(0, 99);
    if (r == 0) return '0;
    if (r == 1) return bno_t'(NBLK - 1);
    return bno_t'($urandom_range(1, NBLK - 1));
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.opcode <= OP_ALLOC;
      req_if.block_number <= '0;
      hold = 0;
    end else begin
      nxt_valid = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        pending_grants.push_back(apply_request(op_e'(req_if.opcode), req_if.block_number));
        issued++;
        n_sent <= issued;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && req_backlog.size() > 0) begin
        if (hold < req_backlog[0].gap) begin
          hold++;
        end else if (!(req_backlog[0].drain && n_got != issued)) begin
          req_if.opcode <= req_backlog[0].op;
          req_if.block_number <= req_backlog[0].bno;
          void'(req_backlog.pop_front());
          nxt_valid = 1'b1;
          hold = 0;
        end
      end
      req_if.valid <= nxt_valid;
    end
  end

  // response monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_stall = 0;
    end else begin
      nxt_ready = rsp_if.ready;
      if (rsp_if.valid && rsp_if.ready) begin
        n_got <= n_got + 1;
        if (pending_grants.size() == 0) begin
          report_mismatch($sformatf("unexpected item block %0d status %0d",
                                    rsp_if.granted_block, rsp_if.status));
        end else begin
          got_exp = pending_grants.pop_front();
          if (rsp_if.granted_block !== got_exp.block)
            report_mismatch($sformatf("granted_block %0d, expected %0d",
                                      rsp_if.granted_block, got_exp.block));
          if (rsp_if.status !== got_exp.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_if.status, got_exp.status));
        end
        if ($urandom_range(0, 29) == 0) rsp_calm = !rsp_calm;
        rsp_stall = rsp_calm ? 0 : $urandom_range(0, 12);
        nxt_ready = (rsp_stall == 0);
      end else if (!rsp_if.ready) begin
        if (rsp_stall > 0) rsp_stall--;
        if (rsp_stall == 0) nxt_ready = 1'b1;
      end
      rsp_if.ready <= nxt_ready;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    freelist_req_t it;
    bit calm;
    int mode;
    int len;
    calm = 0;

    // directed: empty list, block zero, fill, spill, refill, zero base
    it.drain = 0;
    it.op = OP_ALLOC; it.bno = '1; it.gap = 0; req_backlog.push_back(it);
    it.op = OP_FREE;  it.bno = '0; it.gap = 2; req_backlog.push_back(it);
    it.op = OP_ALLOC; it.bno = '0; it.gap = 0; req_backlog.push_back(it);
    for (int k = 0; k < 15; k++) begin
      it.op = OP_FREE;
      it.bno = (k == 0) ? bno_t'(1023) : (k <= 10) ? bno_t'(1 << (k - 1)) :
               (k == 11) ? bno_t'(341) : (k == 12) ? bno_t'(682) :
               (k == 13) ? bno_t'(5) : bno_t'(1000);
      it.gap = $urandom_range(0, 3);
      req_backlog.push_back(it);
    end
    it.op = OP_FREE;  it.bno = 10'd777; it.gap = 0; req_backlog.push_back(it);
    it.op = OP_ALLOC; it.bno = 10'd3;   it.gap = 5; req_backlog.push_back(it);
    it.op = OP_FREE;  it.bno = '0;      it.gap = 0; req_backlog.push_back(it);
    it.op = OP_ALLOC; it.bno = '0;      it.gap = 0; req_backlog.push_back(it);

    // random bursts of frees and allocates, some mixed noise
    for (int n = 0; n < RAND_REQS; ) begin
      mode = $urandom_range(0, 9);
      len = $urandom_range(1, 40);
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len && n < RAND_REQS; k++, n++) begin
        if (mode < 5) it.op = OP_FREE;
        else if (mode < 9) it.op = OP_ALLOC;
        else it.op = $urandom_range(0, 1) ? OP_FREE : OP_ALLOC;
        it.bno = pick_block();
        it.gap = calm ? 0 : $urandom_range(0, 12);
        it.drain = (n == 0) || (n == RAND_REQS / 2);
        req_backlog.push_back(it);
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (req_backlog.size() != 0 || req_if.valid || n_got != n_sent)
      @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);

    if (pending_grants.size() != 0)
      report_mismatch($sformatf("%0d items never returned", pending_grants.size()));
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
